// File: rtl/nca_pkg.sv
// Shared types and constants for the nearest-centroid assignment block.
`default_nettype none

package nca_pkg;

  localparam int VALUE_W  = 16;  // coordinate value width, signed
  localparam int CIDX_W   = 4;   // centroid index field
  localparam int COORD_W  = 10;  // coordinate index field
  localparam int VIDX_W   = 20;  // dataset vector index
  localparam int DIST_W   = 42;  // accumulated squared distance
  localparam int SQ_W     = 2 * VALUE_W;
  localparam int ID_W     = 8;   // internal centroid id, covers up to 256 cells
  localparam int CNT_W    = 5;   // centroid_count register width
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_VEC  = 1'b1;

  // register index (word address bit)
  localparam logic REG_CENTROID_COUNT = 1'b0;

  typedef struct packed {
    logic                      operation;
    logic [CIDX_W-1:0]         centroid_index;
    logic [COORD_W-1:0]        coordinate_index;
    logic signed [VALUE_W-1:0] value;
    logic [VIDX_W-1:0]         vector_index;
    logic                      already_assigned;
    logic                      last_coordinate;
  } in_word_t;

  typedef struct packed {
    logic [VIDX_W-1:0] result_vector_index;
    logic [CIDX_W-1:0] nearest_centroid;
    logic [DIST_W-1:0] squared_distance;
  } out_word_t;

  // running best record handed down the chain on a vector's last coordinate
  typedef struct packed {
    logic [VIDX_W-1:0] vidx;
    logic              emit;
    logic [ID_W-1:0]   idx;
    logic [DIST_W-1:0] dsum;
  } best_t;

endpackage

`default_nettype wire

// File: rtl/nca_chan_if.sv
// Valid/ready channel interface carrying one word per handshake.
`default_nettype none

interface nca_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/nca_apb.sv
// APB-style configuration register file (centroid_count).
`default_nettype none

module nca_apb import nca_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [CNT_W-1:0]  count
);

  logic [CNT_W-1:0] count_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_CENTROID_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
    end else if (wr_en) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CENTROID_COUNT) begin
      prdata = APB_DW'(count_r);
    end
  end

  assign count = count_r;

endmodule

`default_nettype wire

// File: rtl/nca_cell.sv
// One centroid cell: coordinate memory, squarer, accumulator, best-so-far stage.
`default_nettype none

module nca_cell import nca_pkg::*; #(
  parameter int MAX_DIMENSION = 1024,
  parameter int CELL_ID       = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire logic     in_use,
  input  wire logic     tok_vld_i,
  input  wire in_word_t tok_i,
  output logic          tok_vld_o,
  output in_word_t      tok_o,
  input  wire logic     best_vld_i,
  input  wire best_t    best_i,
  output logic          best_vld_o,
  output best_t         best_o
);

  localparam int AW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;

  logic signed [VALUE_W-1:0] mem [MAX_DIMENSION];

  // stage 0: memory access
  logic          coord_ok;
  logic [AW-1:0] addr;
  logic          wr_en;

  // stage 1: difference and square
  logic signed [VALUE_W-1:0] rd_r;
  logic signed [VALUE_W-1:0] s1_val_r;
  logic                      s1_vec_r;
  logic                      s1_cok_r;
  logic                      s1_last_r;
  logic                      s1_emit_r;
  logic [VIDX_W-1:0]         s1_vidx_r;
  logic signed [VALUE_W:0]   diff;
  logic [VALUE_W-1:0]        mag;

  // stage 2: accumulate and compare
  logic [SQ_W-1:0]   sq_r;
  logic              s2_vec_r;
  logic              s2_cok_r;
  logic              s2_last_r;
  logic              s2_emit_r;
  logic [VIDX_W-1:0] s2_vidx_r;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] acc_upd;
  logic [DIST_W-1:0] acc_r;
  logic [DIST_W-1:0] acc_nxt;
  logic              best_vld_nxt;
  best_t             best_nxt;
  logic              take_own;

  assign coord_ok = 32'(tok_i.coordinate_index) < MAX_DIMENSION;
  assign addr     = AW'(tok_i.coordinate_index);
  assign wr_en    = adv && tok_vld_i && (tok_i.operation == OP_LOAD) && coord_ok
                    && (32'(tok_i.centroid_index) == CELL_ID);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= tok_i.value;
    end
    if (adv) begin
      rd_r <= mem[addr];
    end
  end

  assign diff = {s1_val_r[VALUE_W-1], s1_val_r} - {rd_r[VALUE_W-1], rd_r};
  always_comb begin
    if (diff[VALUE_W]) begin
      mag = VALUE_W'(-diff);
    end else begin
      mag = VALUE_W'(diff);
    end
  end

  // saturating accumulate
  assign sum     = {1'b0, acc_r} + (DIST_W + 1)'(sq_r);
  assign acc_upd = (s2_vec_r && s2_cok_r) ? (sum[DIST_W] ? '1 : sum[DIST_W-1:0]) : acc_r;

  // strict less-than keeps the lower index on a tie
  assign take_own = in_use && (!best_vld_i || (acc_upd < best_i.dsum));

  always_comb begin
    best_vld_nxt  = s2_vec_r && s2_last_r;
    best_nxt.vidx = s2_vidx_r;
    best_nxt.emit = s2_emit_r;
    if (take_own) begin
      best_nxt.idx  = ID_W'(CELL_ID);
      best_nxt.dsum = acc_upd;
    end else begin
      best_nxt.idx  = best_i.idx;
      best_nxt.dsum = best_i.dsum;
    end
    acc_nxt = best_vld_nxt ? '0 : acc_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_o  <= 1'b0;
      s1_vec_r   <= 1'b0;
      s2_vec_r   <= 1'b0;
      best_vld_o <= 1'b0;
      acc_r      <= '0;
    end else if (adv) begin
      tok_vld_o  <= tok_vld_i;
      s1_vec_r   <= tok_vld_i && (tok_i.operation == OP_VEC);
      s2_vec_r   <= s1_vec_r;
      best_vld_o <= best_vld_nxt;
      acc_r      <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_o     <= tok_i;
      s1_val_r  <= tok_i.value;
      s1_cok_r  <= coord_ok;
      s1_last_r <= tok_i.last_coordinate;
      s1_emit_r <= !tok_i.already_assigned;
      s1_vidx_r <= tok_i.vector_index;
      sq_r      <= mag * mag;
      s2_cok_r  <= s1_cok_r;
      s2_last_r <= s1_last_r;
      s2_emit_r <= s1_emit_r;
      s2_vidx_r <= s1_vidx_r;
      best_o    <= best_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nearest_centroid_assign.sv
// Top level: nearest-centroid assignment over a chain of centroid cells.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+------------------------------------------
//  in_ch    | in  | valid/ready        | centroid load or vector coordinate
//  out_ch   | out | valid/ready        | vector index, nearest centroid, distance
//  cfg      | in  | APB psel/penable   | centroid_count at byte address 0
//
// One word is taken per cycle and walks down the chain one cell a cycle,
// both while the chain is not stalled; each cell reads its coordinate memory,
// squares the difference and adds it. A vector's result leaves through the
// output register once its last word and best record have passed the chain.
// Reset (synchronous, rst_n low) clears accumulators and valid flags and
// sets centroid_count to 1; centroid memories hold garbage until loaded.
// The chain stalls only when a result reaches its end while the output
// register is still full and out_ch.ready is low; then in_ch.ready drops.
`default_nettype none

module nearest_centroid_assign import nca_pkg::*; #(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_DIMENSION = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  nca_chan_if.sink               in_ch,
  nca_chan_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [CNT_W-1:0] count;

  nca_apb u_apb (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .count   (count)
  );

  // chain wiring
  logic     tok_vld  [MAX_CENTROIDS];
  in_word_t tok      [MAX_CENTROIDS];
  logic     best_vld [MAX_CENTROIDS];
  best_t    best     [MAX_CENTROIDS];
  logic     cell_use [MAX_CENTROIDS];

  logic      adv;
  logic      end_emit;
  logic      stall;
  logic      out_valid_r;
  out_word_t out_word_r;

  assign end_emit    = best_vld[MAX_CENTROIDS-1] && best[MAX_CENTROIDS-1].emit;
  assign stall       = end_emit && out_valid_r && !out_ch.ready;
  assign adv         = !stall;
  assign in_ch.ready = adv;

  genvar k;
  generate
    for (k = 0; k < MAX_CENTROIDS; k++) begin : g_cell
      // count of zero still uses centroid 0; counts past the cell row saturate
      assign cell_use[k] = (k == 0) || (32'(count) > k);

      if (k == 0) begin : g_head
        nca_cell #(.MAX_DIMENSION(MAX_DIMENSION), .CELL_ID(k)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .adv        (adv),
          .in_use     (cell_use[k]),
          .tok_vld_i  (in_ch.valid && adv),
          .tok_i      (in_ch.data),
          .tok_vld_o  (tok_vld[k]),
          .tok_o      (tok[k]),
          .best_vld_i (1'b0),
          .best_i     ('0),
          .best_vld_o (best_vld[k]),
          .best_o     (best[k])
        );
      end else begin : g_body
        nca_cell #(.MAX_DIMENSION(MAX_DIMENSION), .CELL_ID(k)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .adv        (adv),
          .in_use     (cell_use[k]),
          .tok_vld_i  (tok_vld[k-1]),
          .tok_i      (tok[k-1]),
          .tok_vld_o  (tok_vld[k]),
          .tok_o      (tok[k]),
          .best_vld_i (best_vld[k-1]),
          .best_i     (best[k-1]),
          .best_vld_o (best_vld[k]),
          .best_o     (best[k])
        );
      end
    end
  endgenerate

  // output register: a word not yet taken stalls the chain if a new result is due
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && end_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && end_emit) begin
      out_word_r.result_vector_index <= best[MAX_CENTROIDS-1].vidx;
      out_word_r.nearest_centroid    <= best[MAX_CENTROIDS-1].idx[CIDX_W-1:0];
      out_word_r.squared_distance    <= best[MAX_CENTROIDS-1].dsum;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // input backpressure only comes from a full, blocked output register
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready && end_emit))
    else $error("input stalled without a blocked result");

  // a stalled chain end keeps its pending result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (end_emit && $stable(best[MAX_CENTROIDS-1])))
    else $error("pending result changed during stall");

  // chosen centroid is always one in use
  a_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.nearest_centroid == '0
                     || {1'b0, out_word_r.nearest_centroid} < count))
    else $error("nearest centroid outside the in-use range");

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for nearest_centroid_assign: random and directed words, scoreboard.
module tb import nca_pkg::*; ();

  localparam int NUM_CELLS   = 16;
  localparam int NUM_DIMS    = 1024;
  localparam int SETTLE      = 2 * (NUM_CELLS + 3) + 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 195;
  localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 1;
  localparam logic [APB_AW-1:0] COUNT_ADDR = APB_AW'(4 * int'(REG_CENTROID_COUNT));

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  nca_chan_if #(.payload_t(in_word_t))  in_ch ();
  nca_chan_if #(.payload_t(out_word_t)) out_ch ();

  nearest_centroid_assign #(
    .MAX_CENTROIDS(NUM_CELLS),
    .MAX_DIMENSION(NUM_DIMS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Stimulus and scoreboard storage
  in_word_t  pending_words[$];
  out_word_t expected_assignments[$];

  // Predictor state
  logic signed [VALUE_W-1:0] centroid_mem [NUM_CELLS][NUM_DIMS];
  longint unsigned           dist_acc [NUM_CELLS];
  logic [CNT_W-1:0]          count_reg;

  // Generator bookkeeping: a vector word may only use a dimension that every
  // centroid has been loaded at, since all cells read their memory.
  bit written [NUM_CELLS][NUM_DIMS];
  bit dim_ready [NUM_DIMS];
  int ready_dims[$];

  int send_idle_pct;
  int sink_stall_pct;
  int failures;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_word_t make_word(logic op, logic [CIDX_W-1:0] cidx,
                                         logic [COORD_W-1:0] coord,
                                         logic [VALUE_W-1:0] val,
                                         logic [VIDX_W-1:0] vidx,
                                         logic assigned, logic last);
    in_word_t w;
    w.operation        = op;
    w.centroid_index   = cidx;
    w.coordinate_index = coord;
    w.value            = val;
    w.vector_index     = vidx;
    w.already_assigned = assigned;
    w.last_coordinate  = last;
    return w;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return VALUE_W'($urandom_range(6) - 3);        // near zero, ties likely
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic queue_load(int cidx, int coord, logic [VALUE_W-1:0] val);
    bit all_set;
    pending_words = {pending_words,
                     make_word(OP_LOAD, CIDX_W'(cidx), COORD_W'(coord), val,
                               VIDX_W'($urandom), 1'($urandom), 1'($urandom))};
    written[cidx][coord] = 1'b1;
    if (!dim_ready[coord]) begin
      all_set = 1'b1;
      for (int c = 0; c < NUM_CELLS; c++)
        if (!written[c][coord]) all_set = 1'b0;
      if (all_set) begin
        dim_ready[coord] = 1'b1;
        ready_dims = {ready_dims, coord};
      end
    end
  endtask

  task automatic queue_vec(int coord, logic [VALUE_W-1:0] val, logic [VIDX_W-1:0] vidx,
                           logic assigned, logic last);
    pending_words = {pending_words,
                     make_word(OP_VEC, CIDX_W'($urandom), COORD_W'(coord), val, vidx,
                               assigned, last)};
  endtask

  function automatic int pick_dim();
    return ready_dims[$urandom_range(ready_dims.size() - 1)];
  endfunction

  // One well-formed vector with random content; the index and the flag only
  // matter on the last word, elsewhere they are noise.
  task automatic queue_random_vector(output int words);
    logic [VIDX_W-1:0] vidx;
    logic              assigned;
    vidx     = VIDX_W'($urandom);
    assigned = ($urandom_range(99) < 20);
    words    = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    for (int i = 0; i < words; i++) begin
      if (i == words - 1)
        queue_vec(pick_dim(), rand_value(), vidx, assigned, 1'b1);
      else
        queue_vec(pick_dim(), rand_value(), VIDX_W'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  task automatic queue_random_words(int target);
    int made;
    int words;
    int coord;
    made = 0;
    while (made < target) begin
      if ($urandom_range(99) < 20) begin
        if ($urandom_range(99) < 5) begin
          // whole column at a random dimension, opens it up for vectors
          coord = $urandom_range(NUM_DIMS - 1);
          for (int c = 0; c < NUM_CELLS; c++) queue_load(c, coord, rand_value());
          made += NUM_CELLS;
        end else begin
          coord = $urandom_range(1) ? pick_dim() : $urandom_range(NUM_DIMS - 1);
          queue_load($urandom_range(NUM_CELLS - 1), coord, rand_value());
          made++;
        end
      end else begin
        queue_random_vector(words);
        made += words;
      end
    end
  endtask

  // Predictor: runs on every accepted word, in acceptance order.
  function automatic void assign_nearest(in_word_t w);
    int              diff;
    longint unsigned mag;
    longint unsigned sq;
    int              in_use;
    int              best;
    out_word_t       r;
    if (w.operation == OP_LOAD) begin
      centroid_mem[w.centroid_index][w.coordinate_index] = w.value;
      return;
    end
    for (int c = 0; c < NUM_CELLS; c++) begin
      diff = int'($signed(w.value)) - int'(centroid_mem[c][w.coordinate_index]);
      mag  = longint'(diff < 0 ? -diff : diff);
      sq   = mag * mag;
      if (sq > DIST_MAX - dist_acc[c])
        dist_acc[c] = DIST_MAX;               // saturate
      else
        dist_acc[c] = dist_acc[c] + sq;
    end
    if (!w.last_coordinate) return;
    in_use = (count_reg == 0) ? 1 : ((count_reg > NUM_CELLS) ? NUM_CELLS : int'(count_reg));
    best = 0;
    for (int c = 1; c < in_use; c++)
      if (dist_acc[c] < dist_acc[best]) best = c;   // strict: lower index wins ties
    if (!w.already_assigned) begin
      r.result_vector_index = w.vector_index;
      r.nearest_centroid    = CIDX_W'(best);
      r.squared_distance    = DIST_W'(dist_acc[best]);
      expected_assignments = {expected_assignments, r};
    end
    for (int c = 0; c < NUM_CELLS; c++) dist_acc[c] = 0;
  endfunction

  function automatic void note_failure(string msg);
    if (failures < 10) $display("%s", msg);
    failures++;
  endfunction

  function automatic void check_assignment(out_word_t got);
    out_word_t want;
    if (expected_assignments.size() == 0) begin
      note_failure($sformatf("unexpected result: vidx=%0h centroid=%0d dist=%0h",
                             got.result_vector_index, got.nearest_centroid,
                             got.squared_distance));
      return;
    end
    want = expected_assignments.pop_front();
    if (got.result_vector_index !== want.result_vector_index ||
        got.nearest_centroid !== want.nearest_centroid ||
        got.squared_distance !== want.squared_distance)
      note_failure($sformatf({"mismatch: expected vidx=%0h centroid=%0d dist=%0h, ",
                              "got vidx=%0h centroid=%0d dist=%0h"},
                             want.result_vector_index, want.nearest_centroid,
                             want.squared_distance, got.result_vector_index,
                             got.nearest_centroid, got.squared_distance));
  endfunction

  // Driver: next word goes out only once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.data  <= pending_words.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Scoreboard: predict on input handshakes, check on output handshakes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) assign_nearest(in_ch.data);
      if (out_ch.valid && out_ch.ready) check_assignment(out_ch.data);
    end
  end

  // Waits until every queued word is taken and every result is back, then
  // lets the chain drain so words with no result have left it too.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_assignments.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_centroid_count(logic [CNT_W-1:0] n);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= {(APB_DW - CNT_W)'($urandom), n};   // upper bits are don't-care
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    count_reg = n;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int idle_table [4];
    int stall_table [4];
    idle_table  = '{0, 61, 0, 30};
    stall_table = '{0, 0, 61, 30};

    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    failures     = 0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    count_reg    = CNT_W'(1);
    for (int c = 0; c < NUM_CELLS; c++) dist_acc[c] = 0;

    // Setup: load all centroids at a handful of dimensions. Dimension 0
    // carries the value extremes, 1023 is all zero (everyone ties), and at
    // 512 centroids 7 and 9 are identical and far from the rest.
    for (int c = 0; c < NUM_CELLS; c++) begin
      queue_load(c, 0, (c == 0) ? 16'h8000 : ((c == NUM_CELLS - 1) ? 16'h7FFF : rand_value()));
      for (int d = 1; d < 4; d++) queue_load(c, d, VALUE_W'($urandom));
      queue_load(c, 512, (c == 7 || c == 9) ? 16'sd100 : -16'sd20000);
      queue_load(c, NUM_DIMS - 1, '0);
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset count of one: only centroid 0 is eligible, max difference.
    queue_vec(0, 16'h7FFF, '0, 1'b0, 1'b1);
    wait_drained();
    write_centroid_count(CNT_W'(NUM_CELLS));
    // All distances zero: the tie goes to centroid 0.
    queue_vec(NUM_DIMS - 1, '0, 20'hFFFFF, 1'b0, 1'b1);
    // Already assigned vector gives nothing, but must clear the accumulators.
    queue_vec(1, VALUE_W'($urandom), VIDX_W'($urandom), 1'b0, 1'b0);
    queue_vec(2, VALUE_W'($urandom), VIDX_W'($urandom), 1'b1, 1'b0);
    queue_vec(3, VALUE_W'($urandom), 20'h12345, 1'b1, 1'b1);
    queue_vec(NUM_DIMS - 1, 16'h8000, 20'h00001, 1'b0, 1'b1);
    // Tie between two inner centroids: lower one wins.
    queue_vec(512, 16'sd100, 20'h80000, 1'b0, 1'b1);
    // Repeated dimension within one vector.
    queue_vec(0, rand_value(), VIDX_W'($urandom), 1'b0, 1'b0);
    queue_vec(2, rand_value(), VIDX_W'($urandom), 1'b0, 1'b0);
    queue_vec(2, rand_value(), VIDX_W'($urandom), 1'b0, 1'b0);
    queue_vec(3, rand_value(), VIDX_W'($urandom), 1'b0, 1'b0);
    queue_vec(1, rand_value(), 20'h7FFFF, 1'b0, 1'b1);
    wait_drained();
    // Count above the cell total saturates.
    write_centroid_count(CNT_W'(31));
    queue_vec(0, rand_value(), VIDX_W'($urandom), 1'b0, 1'b0);
    queue_vec(1, rand_value(), 20'h0F0F0, 1'b0, 1'b1);
    wait_drained();
    // Count of zero acts as one: centroid 0 wins although 7 and 9 are closer.
    write_centroid_count('0);
    queue_vec(512, 16'sd100, 20'h5A5A5, 1'b0, 1'b1);
    wait_drained();

    // Random phases; each starts from an idle block with a new count.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: write_centroid_count(CNT_W'(NUM_CELLS));
        1: write_centroid_count(CNT_W'($urandom_range(2, NUM_CELLS - 1)));
        2: write_centroid_count(CNT_W'(1));
        default: write_centroid_count(CNT_W'($urandom_range(31)));
      endcase
      send_idle_pct  = idle_table[p];
      sink_stall_pct = stall_table[p];
      queue_random_words(PHASE_WORDS);
      wait_drained();
    end

    if (failures == 0 && expected_assignments.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
